### design/pidaw_pkg.sv
// Shared types, widths and codes for the PID controller with anti-windup.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package pidaw_pkg;

  localparam int DATA_W             = 16;
  localparam int TICK_W             = 16;
  localparam int GAIN_FRACTION_BITS = 8;
  localparam int INTEGRAL_WIDTH     = 48;
  localparam int INTEGRAL_SCALE     = 16;

  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_P      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_I      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_D      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_DRIVE_UPPER = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_DRIVE_LOWER = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_HOLD        = 3'd5;

  localparam int MUL_A_W = DATA_W + 1;
  localparam int MUL_B_W = (INTEGRAL_WIDTH - INTEGRAL_SCALE > MUL_A_W) ?
                           (INTEGRAL_WIDTH - INTEGRAL_SCALE) : MUL_A_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int SUM_W   = ((INTEGRAL_WIDTH > 2 * DATA_W + 1) ?
                            INTEGRAL_WIDTH : (2 * DATA_W + 1)) + 2;
  localparam int UNL_W   = SUM_W - GAIN_FRACTION_BITS;
  localparam int DVD_W   = 2 * DATA_W;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);
  localparam int INC_W   = INTEGRAL_WIDTH + 2;

  localparam logic signed [INC_W-1:0] INT_MAX =
    INC_W'({1'b0, {(INTEGRAL_WIDTH-1){1'b1}}});
  localparam logic signed [INC_W-1:0] INT_MIN = -INT_MAX - INC_W'(1);

  typedef struct packed {
    logic                     operation;
    logic signed [DATA_W-1:0] error_in;
    logic [TICK_W-1:0]        elapsed_ticks;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     limited;
  } out_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] gain_p;
    logic signed [DATA_W-1:0] gain_i;
    logic signed [DATA_W-1:0] gain_d;
    logic signed [DATA_W-1:0] drive_upper;
    logic signed [DATA_W-1:0] drive_lower;
    logic                     integrator_hold;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_ACC_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_MUL_INC,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    MSEL_P,
    MSEL_I,
    MSEL_D,
    MSEL_INC
  } msel_t;

  typedef struct packed {
    logic  accept;
    logic  mul_go;
    msel_t mul_sel;
    logic  acc_load;
    logic  acc_add_mul;
    logic  acc_add_div;
    logic  div_start;
    logic  finish;
  } ctrl_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [TICK_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

### design/pidaw_mul.sv
// Shared signed multiplier with a registered product.
// Depends on pidaw_pkg for the operand and product widths.
`timescale 1ns / 1ps

module pidaw_mul
  import pidaw_pkg::*;
(
  input  logic                      clk,
  input  logic                      go,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [PROD_W-1:0]  prod_r
);

  logic signed [PROD_W-1:0] prod_nxt;

  assign prod_nxt = PROD_W'(a) * PROD_W'(b);

  always_ff @(posedge clk) begin
    if (go) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

### design/pidaw_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pidaw_pkg for the request and response structs.
`timescale 1ns / 1ps

module pidaw_div
  import pidaw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic [DVD_W-1:0]     dvd_r, dvd_nxt;
  logic [TICK_W-1:0]    rem_r, rem_nxt;
  logic [TICK_W-1:0]    dsr_r, dsr_nxt;
  logic [TICK_W:0]      shifted;
  logic [TICK_W:0]      diff;

  always_comb begin
    shifted  = {rem_r, dvd_r[DVD_W-1]};
    diff     = shifted - {1'b0, dsr_r};
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    done_nxt = 1'b0;
    if (req.start) begin
      cnt_nxt = DIV_CNT_W'(DVD_W);
      dvd_nxt = req.dividend;
      rem_nxt = '0;
      dsr_nxt = req.divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - DIV_CNT_W'(1);
      done_nxt = (cnt_r == DIV_CNT_W'(1));
      if (!diff[TICK_W]) begin
        rem_nxt = diff[TICK_W-1:0];
        dvd_nxt = {dvd_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[TICK_W-1:0];
        dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule

### design/pidaw_core.sv
// Sequencer, accumulator, controller state and output register of the PID block.
// Depends on pidaw_pkg, pidaw_mul and pidaw_div.
`timescale 1ns / 1ps

module pidaw_core
  import pidaw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  state_t state_r, state_nxt;
  ctrl_t  ctrl;

  logic                     op_r, op_nxt;
  logic signed [DATA_W-1:0] err_r, err_nxt;
  logic [TICK_W-1:0]        ticks_r, ticks_nxt;
  logic                     dneg_r, dneg_nxt;
  logic signed [SUM_W-1:0]  acc_r, acc_nxt;

  logic                             started_r, started_nxt;
  logic signed [INTEGRAL_WIDTH-1:0] integral_r, integral_nxt;
  logic signed [DATA_W-1:0]         prev_r, prev_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r, out_word_nxt;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p_r;
  logic signed [MUL_A_W-1:0] err_diff;
  logic signed [MUL_A_W-1:0] err_pair;
  logic signed [PROD_W-1:0]  prod_mag;
  logic signed [DVD_W:0]     quot_s;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [UNL_W-1:0] unlim;
  logic signed [UNL_W-1:0] upper_x;
  logic signed [UNL_W-1:0] lower_x;
  logic signed [UNL_W-1:0] lim_hi;
  logic signed [UNL_W-1:0] lim;
  logic                    opposing;
  logic signed [INC_W-1:0] inc;
  logic signed [INC_W-1:0] isum;
  logic                    do_integrate;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_word.operation ? ST_FINISH : ST_MUL_P;
        end
      end
      ST_MUL_P:   state_nxt = started_r ? ST_MUL_I : ST_ACC_P;
      ST_ACC_P:   state_nxt = ST_FINISH;
      ST_MUL_I:   state_nxt = ST_MUL_D;
      ST_MUL_D:   state_nxt = ST_MUL_INC;
      ST_MUL_INC: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!(out_valid_r && out_stall)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    ctrl.mul_sel = MSEL_P;
    case (state_r)
      ST_IDLE: ctrl.accept = in_valid;
      ST_MUL_P: begin
        ctrl.mul_go  = 1'b1;
        ctrl.mul_sel = MSEL_P;
      end
      ST_ACC_P: ctrl.acc_load = 1'b1;
      ST_MUL_I: begin
        ctrl.acc_load = 1'b1;
        ctrl.mul_go   = 1'b1;
        ctrl.mul_sel  = MSEL_I;
      end
      ST_MUL_D: begin
        ctrl.acc_add_mul = 1'b1;
        ctrl.mul_go      = 1'b1;
        ctrl.mul_sel     = MSEL_D;
      end
      ST_MUL_INC: begin
        ctrl.div_start = 1'b1;
        ctrl.mul_go    = 1'b1;
        ctrl.mul_sel   = MSEL_INC;
      end
      ST_DIV:    ctrl.acc_add_div = div_rsp.done;
      ST_FINISH: ctrl.finish = !(out_valid_r && out_stall);
      default:   ctrl = '0;
    endcase
  end

  assign err_diff = MUL_A_W'(err_r) - MUL_A_W'(prev_r);
  assign err_pair = MUL_A_W'(err_r) + MUL_A_W'(prev_r);

  always_comb begin
    case (ctrl.mul_sel)
      MSEL_P: begin
        mul_a = MUL_A_W'(cfg.gain_p);
        mul_b = MUL_B_W'(err_r);
      end
      MSEL_I: begin
        mul_a = MUL_A_W'(cfg.gain_i);
        mul_b = MUL_B_W'(integral_r >>> INTEGRAL_SCALE);
      end
      MSEL_D: begin
        mul_a = MUL_A_W'(cfg.gain_d);
        mul_b = MUL_B_W'(err_diff);
      end
      MSEL_INC: begin
        mul_a = err_pair;
        mul_b = MUL_B_W'($signed({1'b0, ticks_r}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pidaw_mul u_mul (
    .clk    (clk),
    .go     (ctrl.mul_go),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (mul_p_r)
  );

  assign prod_mag         = mul_p_r[PROD_W-1] ? -mul_p_r : mul_p_r;
  assign div_req.start    = ctrl.div_start;
  assign div_req.dividend = prod_mag[DVD_W-1:0];
  assign div_req.divisor  = ticks_r;

  pidaw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign quot_s = dneg_r ? -$signed({1'b0, div_rsp.quotient})
                         : $signed({1'b0, div_rsp.quotient});

  assign unlim    = UNL_W'(acc_r >>> GAIN_FRACTION_BITS);
  assign upper_x  = UNL_W'(cfg.drive_upper);
  assign lower_x  = UNL_W'(cfg.drive_lower);
  assign lim_hi   = (unlim < upper_x) ? unlim : upper_x;
  assign lim      = (lim_hi > lower_x) ? lim_hi : lower_x;
  assign opposing = ((acc_r > 0) && (err_r < 0)) || ((acc_r < 0) && (err_r > 0));
  assign inc      = INC_W'(mul_p_r >>> 1);
  assign isum     = INC_W'(integral_r) + inc;
  assign do_integrate = started_r && !cfg.integrator_hold &&
                        ((unlim == lim) || opposing);

  always_comb begin
    op_nxt        = op_r;
    err_nxt       = err_r;
    ticks_nxt     = ticks_r;
    dneg_nxt      = dneg_r;
    acc_nxt       = acc_r;
    started_nxt   = started_r;
    integral_nxt  = integral_r;
    prev_nxt      = prev_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (ctrl.accept) begin
      op_nxt    = in_word.operation;
      err_nxt   = in_word.error_in;
      ticks_nxt = (in_word.elapsed_ticks == '0) ? TICK_W'(1) : in_word.elapsed_ticks;
    end
    if (ctrl.acc_load) begin
      acc_nxt = SUM_W'(mul_p_r);
    end
    if (ctrl.acc_add_mul) begin
      acc_nxt = acc_r + SUM_W'(mul_p_r);
    end
    if (ctrl.acc_add_div) begin
      acc_nxt = acc_r + SUM_W'(quot_s);
    end
    if (ctrl.div_start) begin
      dneg_nxt = mul_p_r[PROD_W-1];
    end
    if (ctrl.finish) begin
      out_valid_nxt = 1'b1;
      if (op_r) begin
        started_nxt          = 1'b0;
        integral_nxt         = '0;
        prev_nxt             = '0;
        out_word_nxt.drive   = '0;
        out_word_nxt.limited = 1'b0;
      end else begin
        started_nxt          = 1'b1;
        prev_nxt             = err_r;
        out_word_nxt.drive   = lim[DATA_W-1:0];
        out_word_nxt.limited = (unlim != lim);
        if (do_integrate) begin
          if (isum > INT_MAX) begin
            integral_nxt = INT_MAX[INTEGRAL_WIDTH-1:0];
          end else if (isum < INT_MIN) begin
            integral_nxt = INT_MIN[INTEGRAL_WIDTH-1:0];
          end else begin
            integral_nxt = isum[INTEGRAL_WIDTH-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      started_r   <= 1'b0;
      integral_r  <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      integral_r  <= integral_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    err_r      <= err_nxt;
    ticks_r    <= ticks_nxt;
    dneg_r     <= dneg_nxt;
    acc_r      <= acc_nxt;
    out_word_r <= out_word_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

### design/pid_antiwindup_controller_top.sv
// PID controller with conditional-integration anti-windup: top level.
// Holds the configuration registers; depends on pidaw_pkg and pidaw_core.
//
// Usage: each input word carries an operation, an error and the ticks since
// the previous sample, and is accepted when in_valid is high and in_stall is
// low. Every accepted word yields exactly one result word with the clamped
// drive and a limited flag, taken when out_valid is high and out_stall low.
// A control sample takes the proportional, integral and derivative products
// and the integral increment in turn on the shared multiplier, then waits for
// the bit-serial divider to divide the derivative product by the ticks. A
// first sample takes only the proportional product; a clear word goes straight
// to its result. One word is in flight at a time, and in_stall stays high
// until its result has been placed in the output register; a result that the
// receiver stalls is held there, and a finished word waits for that register
// to empty before the next word is accepted. Reset clears the controller
// state, sets the gains to zero and the drive limits to the full 16-bit range.
// Configuration is written through cfg_we, cfg_addr and cfg_wdata; the user
// must do so only while the block is idle, which the block does not enforce.
`timescale 1ns / 1ps

module pid_antiwindup_controller_top
  import pidaw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [DATA_W-1:0]     cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_GAIN_P:      cfg_nxt.gain_p          = cfg_wdata;
        CFG_GAIN_I:      cfg_nxt.gain_i          = cfg_wdata;
        CFG_GAIN_D:      cfg_nxt.gain_d          = cfg_wdata;
        CFG_DRIVE_UPPER: cfg_nxt.drive_upper     = cfg_wdata;
        CFG_DRIVE_LOWER: cfg_nxt.drive_lower     = cfg_wdata;
        CFG_HOLD:        cfg_nxt.integrator_hold = cfg_wdata[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p          <= '0;
      cfg_r.gain_i          <= '0;
      cfg_r.gain_d          <= '0;
      cfg_r.drive_upper     <= 16'sh7FFF;
      cfg_r.drive_lower     <= 16'sh8000;
      cfg_r.integrator_hold <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pidaw_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

### tb/pidaw_checker.sv
// Scoreboard for the PID controller: watches the configuration port and both
// word channels, predicts each result word and compares it field by field.
// Depends on pidaw_pkg for the word types, widths and register indexes.
`timescale 1ns / 1ps

module pidaw_checker
  import pidaw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [DATA_W-1:0]     cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_word_t              in_word,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_word_t             out_word,
  output int                    mismatches,
  output int                    pending
);

  localparam longint INTEG_MAX = (longint'(1) <<< (INTEGRAL_WIDTH - 1)) - 1;
  localparam longint INTEG_MIN = -INTEG_MAX - 1;

  longint kp, ki, kd, upper_lim, lower_lim;
  logic   freeze;

  logic   seen_sample;
  longint integral_acc;
  longint last_error;

  out_word_t drive_q[$];
  int        fail_total;

  function automatic out_word_t compute_drive(in_word_t w);
    longint    err, ticks, sum, unclamped, clamped, step;
    logic      opposing;
    out_word_t r;
    err   = longint'(w.error_in);
    ticks = longint'(w.elapsed_ticks);
    r     = '0;
    if (w.operation) begin
      seen_sample  = 1'b0;
      integral_acc = 0;
      last_error   = 0;
      return r;
    end
    if (ticks == 0) ticks = 1;
    if (!seen_sample) begin
      sum = kp * err;
    end else begin
      sum = kp * err + ki * (integral_acc >>> INTEGRAL_SCALE)
          + (kd * (err - last_error)) / ticks;
    end
    unclamped = sum >>> GAIN_FRACTION_BITS;
    clamped   = (unclamped < upper_lim) ? unclamped : upper_lim;
    if (clamped < lower_lim) clamped = lower_lim;
    opposing = (sum > 0 && err < 0) || (sum < 0 && err > 0);
    if (seen_sample && !freeze && (unclamped == clamped || opposing)) begin
      step = ((last_error + err) * ticks) >>> 1;
      if (step > 0 && integral_acc > INTEG_MAX - step) integral_acc = INTEG_MAX;
      else if (step < 0 && integral_acc < INTEG_MIN - step) integral_acc = INTEG_MIN;
      else integral_acc = integral_acc + step;
    end
    seen_sample = 1'b1;
    last_error  = err;
    r.drive     = clamped[DATA_W-1:0];
    r.limited   = (unclamped != clamped);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_word_t want;
    if (!rst_n) begin
      kp           = 0;
      ki           = 0;
      kd           = 0;
      upper_lim    = 32767;
      lower_lim    = -32768;
      freeze       = 1'b0;
      seen_sample  = 1'b0;
      integral_acc = 0;
      last_error   = 0;
      fail_total   = 0;
      drive_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_GAIN_P:      kp = $signed(cfg_wdata);
          CFG_GAIN_I:      ki = $signed(cfg_wdata);
          CFG_GAIN_D:      kd = $signed(cfg_wdata);
          CFG_DRIVE_UPPER: upper_lim = $signed(cfg_wdata);
          CFG_DRIVE_LOWER: lower_lim = $signed(cfg_wdata);
          CFG_HOLD:        freeze = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (drive_q.size() == 0) begin
          $error("unexpected result word: drive %0d limited %0b",
                 out_word.drive, out_word.limited);
          fail_total++;
        end else begin
          want = drive_q.pop_front();
          if (out_word.drive !== want.drive) begin
            $error("drive: expected %0d, got %0d", want.drive, out_word.drive);
            fail_total++;
          end
          if (out_word.limited !== want.limited) begin
            $error("limited: expected %0b, got %0b", want.limited, out_word.limited);
            fail_total++;
          end
        end
      end
      if (in_valid && !in_stall) drive_q.push_back(compute_drive(in_word));
    end
    mismatches <= fail_total;
    pending    <= drive_q.size();
  end

endmodule

### tb/pid_antiwindup_controller_top_tb.sv
// Top of the PID controller testbench: clock, reset, configuration phases,
// sample stimulus with random idling on both channels and the final verdict.
// Depends on pidaw_pkg, pid_antiwindup_controller_top and pidaw_checker.
`timescale 1ns / 1ps

module pid_antiwindup_controller_top_tb;
  import pidaw_pkg::*;

  localparam logic OP_SAMPLE        = 1'b0;
  localparam logic OP_CLEAR         = 1'b1;
  localparam int   PHASES           = 10;
  localparam int   SAMPLES_PER_PHASE = 95;
  localparam int   WATCHDOG_LIMIT   = 3000;
  localparam int   HOLD_OFF_CYCLES  = 300;

  typedef enum logic [1:0] {
    BURST_NOISE,
    BURST_STEADY,
    BURST_EXTREME,
    BURST_WALK
  } burst_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [DATA_W-1:0]     cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_word_t              in_word   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_word;

  logic quiet = 1'b0;
  int   mismatches;
  int   pending;
  int   idle_cycles = 0;

  pid_antiwindup_controller_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  pidaw_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  function automatic cfg_t make_cfg(logic [DATA_W-1:0] p, logic [DATA_W-1:0] i,
                                    logic [DATA_W-1:0] d, logic [DATA_W-1:0] up,
                                    logic [DATA_W-1:0] lo, logic hold);
    cfg_t c;
    c.gain_p          = p;
    c.gain_i          = i;
    c.gain_d          = d;
    c.drive_upper     = up;
    c.drive_lower     = lo;
    c.integrator_hold = hold;
    return c;
  endfunction

  function automatic logic [DATA_W-1:0] rand_gain();
    if ($urandom_range(0, 2) == 0) return DATA_W'($urandom);
    return DATA_W'($urandom_range(0, 1023)) - DATA_W'(512);
  endfunction

  task automatic put_reg(logic [CFG_ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic write_config(cfg_t c);
    put_reg(CFG_GAIN_P, c.gain_p);
    put_reg(CFG_GAIN_I, c.gain_i);
    put_reg(CFG_GAIN_D, c.gain_d);
    put_reg(CFG_DRIVE_UPPER, c.drive_upper);
    put_reg(CFG_DRIVE_LOWER, c.drive_lower);
    put_reg(CFG_HOLD, {{(DATA_W-1){1'b0}}, c.integrator_hold});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_word(logic op, logic signed [DATA_W-1:0] err,
                           logic [TICK_W-1:0] ticks);
    in_word_t w;
    w.operation     = op;
    w.error_in      = err;
    w.elapsed_ticks = ticks;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    cfg_t                     settings;
    logic signed [DATA_W-1:0] err;
    logic signed [DATA_W-1:0] level;
    logic signed [DATA_W-1:0] lim_a;
    logic signed [DATA_W-1:0] lim_b;
    logic [TICK_W-1:0]        ticks;
    burst_t                   burst;
    int                       burst_left;
    burst_left = 0;
    level      = '0;
    burst      = BURST_NOISE;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0, PHASES - 1:
          settings = make_cfg(16'h0100, 16'h0100, 16'h0100, 16'h7FFF, 16'h8000, 1'b0);
        1: settings = make_cfg(16'h7FFF, 16'h8000, 16'h7FFF, 16'd1000, -16'sd1000, 1'b0);
        2: settings = make_cfg(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b1);
        3: settings = make_cfg(16'h0080, 16'h0400, 16'h0100, -16'sd50, 16'sd50, 1'b0);
        4: settings = make_cfg(16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 1'b0);
        default: begin
          lim_a = DATA_W'($urandom);
          lim_b = DATA_W'($urandom);
          if ($urandom_range(0, 4) != 0 && lim_a < lim_b) begin
            settings = make_cfg(rand_gain(), rand_gain(), rand_gain(), lim_b, lim_a,
                                1'($urandom));
          end else begin
            settings = make_cfg(rand_gain(), rand_gain(), rand_gain(), lim_a, lim_b,
                                1'($urandom));
          end
        end
      endcase
      if (phase == PHASES - 1) quiet <= 1'b1;
      write_config(settings);

      case (phase)
        0: begin
          send_word(OP_CLEAR, 16'sh7FFF, 16'hFFFF);
          send_word(OP_SAMPLE, 16'sh7FFF, 16'h0000);
          send_word(OP_SAMPLE, 16'sh8000, 16'h0000);
          send_word(OP_SAMPLE, 16'sh7FFF, 16'hFFFF);
          send_word(OP_SAMPLE, 16'sh8000, 16'hFFFF);
          send_word(OP_SAMPLE, 16'sh0000, 16'h0001);
          send_word(OP_SAMPLE, -16'sd1, 16'h0000);
          send_word(OP_CLEAR, 16'sh8000, 16'h0000);
          send_word(OP_SAMPLE, 16'sh8000, 16'h0005);
          send_word(OP_SAMPLE, 16'sd500, 16'h0007);
        end
        1: begin
          send_word(OP_CLEAR, 16'sh0000, 16'h0000);
          send_word(OP_SAMPLE, 16'sh7FFF, 16'h0001);
          send_word(OP_SAMPLE, 16'sh7FFF, 16'h0001);
          send_word(OP_SAMPLE, 16'sh8000, 16'h0001);
          send_word(OP_SAMPLE, 16'sh0000, 16'h0000);
          send_word(OP_SAMPLE, 16'sd100, 16'hFFFF);
        end
        3: send_word(OP_SAMPLE, 16'sh0000, 16'h0002);
        default: ;
      endcase

      for (int n = 0; n < SAMPLES_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(8, 40);
          burst      = burst_t'($urandom_range(0, 3));
          level      = DATA_W'($urandom);
        end
        burst_left--;
        case (burst)
          BURST_STEADY: err = level + DATA_W'($urandom_range(0, 63)) - 16'sd32;
          BURST_EXTREME: begin
            case ($urandom_range(0, 4))
              0: err = 16'sh7FFF;
              1: err = 16'sh8000;
              2: err = 16'sd1;
              3: err = -16'sd1;
              default: err = '0;
            endcase
          end
          BURST_WALK: begin
            level = level + DATA_W'($urandom_range(0, 255)) - 16'sd128;
            err   = level;
          end
          default: err = DATA_W'($urandom);
        endcase
        case ($urandom_range(0, 5))
          0: ticks = '0;
          1: ticks = 16'd1;
          2: ticks = TICK_W'($urandom_range(2, 16));
          3: ticks = 16'hFFFF;
          default: ticks = TICK_W'($urandom);
        endcase
        send_word(($urandom_range(0, 24) == 0) ? OP_CLEAR : OP_SAMPLE, err, ticks);
      end

      in_valid <= 1'b0;
      do @(posedge clk); while (pending != 0);
      repeat (4) @(posedge clk);
    end

    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("pid_antiwindup_controller_top test passed");
    end else begin
      $display("pid_antiwindup_controller_top test failed");
    end
    $finish;
  end

  // The receiver stalls in short bursts and, twice, for a long stretch so
  // that the block fills up and holds off the sender.
  initial begin : receiver
    int taken;
    int next_hold_off;
    taken         = 0;
    next_hold_off = 200;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) taken++;
      if (!quiet && taken >= next_hold_off) begin
        next_hold_off += 400;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("pid_antiwindup_controller_top test failed");
      $finish;
    end
  end

endmodule
